FILE: hw/rtl/sas_pkg.sv
`timescale 1ns / 1ps

package sas_pkg;

  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [6:0] MAX_ARGS_RESET = 7'd100;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_VT        = 8'h0b;
  localparam logic [7:0] CH_FF        = 8'h0c;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_END_ARG  = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_UNBAL    = 3'd3,
    KIND_TOO_MANY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef struct packed {
    logic       in_argument;
    quote_t     quote_mode;
    logic       escape_pending;
    logic [6:0] argument_count;
    logic       drop_until_eol;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    in_argument:    1'b0,
    quote_mode:     Q_NONE,
    escape_pending: 1'b0,
    argument_count: 7'd0,
    drop_until_eol: 1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] arg_index;
    kind_t      kind;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]                    n;
    result_t [MAX_RESULTS-1:0]     r;
  } packet_t;

  // Replacement for an escape letter; zero when the byte is no escape.
  function automatic logic [7:0] escape_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      case (c)
        8'h61:        v = CH_BEL;  // a
        8'h62:        v = CH_BS;   // b
        8'h66:        v = CH_FF;   // f
        8'h6e:        v = CH_LF;   // n
        8'h72:        v = CH_CR;   // r
        8'h74:        v = CH_TAB;  // t
        8'h76:        v = CH_VT;   // v
        CH_BACKSLASH: v = CH_BACKSLASH;
        CH_SQUOTE:    v = CH_SQUOTE;
        CH_DQUOTE:    v = CH_DQUOTE;
        default:      v = 8'h00;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: hw/rtl/sas_step.sv
`timescale 1ns / 1ps

module sas_step import sas_pkg::*; (
  input  logic [7:0]  in_byte,
  input  logic        end_of_line,
  input  line_state_t cur,
  input  logic [6:0]  max_args,
  output line_state_t nxt,
  output packet_t     pkt
);

  always_comb begin
    line_state_t st;
    packet_t     pk;
    logic [7:0]  esc_val;
    quote_t      qq;
    logic        do_plain;

    st       = cur;
    pk       = '0;
    esc_val  = escape_value(in_byte);
    qq       = (in_byte == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
    do_plain = !cur.escape_pending || (esc_val == 8'h00);

    if (end_of_line) begin
      if (!cur.drop_until_eol) begin
        // dangling backslash becomes a literal and opens an argument
        if (cur.escape_pending) begin
          st.in_argument = 1'b1;
          pk.r[pk.n] = '{CH_BACKSLASH, st.argument_count, KIND_CHAR, 1'b0};
          pk.n = pk.n + 2'd1;
        end
        if (st.quote_mode != Q_NONE) begin
          pk.r[pk.n] = '{8'h00, st.argument_count, KIND_UNBAL, 1'b1};
          pk.n = pk.n + 2'd1;
        end else begin
          if (st.in_argument) begin
            pk.r[pk.n] = '{8'h00, st.argument_count, KIND_END_ARG, 1'b0};
            pk.n = pk.n + 2'd1;
          end
          pk.r[pk.n] = '{8'h00, st.argument_count, KIND_DONE, 1'b1};
          pk.n = pk.n + 2'd1;
        end
      end
      st = LINE_CLEAR;
    end else if (!cur.drop_until_eol) begin
      if (cur.escape_pending) begin
        st.escape_pending = 1'b0;
        st.in_argument    = 1'b1;
        pk.r[pk.n] = '{(esc_val != 8'h00) ? esc_val : CH_BACKSLASH,
                       st.argument_count, KIND_CHAR, 1'b0};
        pk.n = pk.n + 2'd1;
      end

      if (do_plain) begin
        case (in_byte)
          CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
            if (st.in_argument) begin
              if (st.quote_mode == Q_NONE) begin
                pk.r[pk.n] = '{8'h00, st.argument_count, KIND_END_ARG, 1'b0};
                pk.n = pk.n + 2'd1;
                st.argument_count = st.argument_count + 7'd1;
                st.in_argument    = 1'b0;
              end else begin
                pk.r[pk.n] = '{in_byte, st.argument_count, KIND_CHAR, 1'b0};
                pk.n = pk.n + 2'd1;
              end
            end
          end
          CH_DQUOTE, CH_SQUOTE: begin
            if (!st.in_argument) begin
              st.in_argument = 1'b1;
              st.quote_mode  = qq;
            end else if (st.quote_mode == qq) begin
              st.quote_mode = Q_NONE;
            end else if (st.quote_mode == Q_NONE) begin
              st.quote_mode = qq;
            end else begin
              pk.r[pk.n] = '{in_byte, st.argument_count, KIND_CHAR, 1'b0};
              pk.n = pk.n + 2'd1;
            end
          end
          CH_BACKSLASH: begin
            if (st.quote_mode != Q_SINGLE) begin
              st.escape_pending = 1'b1;
            end else begin
              st.in_argument = 1'b1;
              pk.r[pk.n] = '{in_byte, st.argument_count, KIND_CHAR, 1'b0};
              pk.n = pk.n + 2'd1;
            end
          end
          default: begin
            st.in_argument = 1'b1;
            pk.r[pk.n] = '{in_byte, st.argument_count, KIND_CHAR, 1'b0};
            pk.n = pk.n + 2'd1;
          end
        endcase
      end

      // argument limit ends the line and drops bytes up to end of line
      if (st.argument_count >= max_args) begin
        pk.r[pk.n] = '{8'h00, st.argument_count, KIND_TOO_MANY, 1'b1};
        pk.n = pk.n + 2'd1;
        st.drop_until_eol = 1'b1;
      end
    end

    nxt = st;
    pkt = pk;
  end

endmodule

FILE: hw/rtl/sas_outq.sv
`timescale 1ns / 1ps

module sas_outq import sas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  packet_t    pkt,
  output logic       free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [6:0] arg_index,
  output logic [2:0] kind,
  output logic       last
);

  result_t [MAX_RESULTS-1:0] slots;
  logic [1:0]                remaining;
  logic [1:0]                head;
  logic                      take;
  result_t                   head_res;

  assign out_valid = (remaining != 2'd0);
  assign take      = out_valid && !out_stall;
  assign free      = (remaining == 2'd0) || ((remaining == 2'd1) && take);

  always_comb begin
    case (head)
      2'd0:    head_res = slots[0];
      2'd1:    head_res = slots[1];
      2'd2:    head_res = slots[2];
      default: head_res = slots[0];
    endcase
  end

  assign out_byte  = head_res.out_byte;
  assign arg_index = head_res.arg_index;
  assign kind      = head_res.kind;
  assign last      = head_res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      head      <= 2'd0;
    end else if (load) begin
      remaining <= pkt.n;
      head      <= 2'd0;
    end else if (take) begin
      remaining <= remaining - 2'd1;
      head      <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= pkt.r;
    end
  end

endmodule

FILE: hw/rtl/shell_argument_splitter_unit.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------
// in       | in_valid / in_stall  | in_byte, end_of_line
// out      | out_valid / out_stall| out_byte, arg_index, kind, last
// cfg      | cfg_valid / cfg_ready| max_args
//
// An accepted byte sits in the input register until the output queue is
// free, then the splitter logic turns it into zero to three results held in
// the output queue. One byte per cycle is sustained while each byte gives at
// most one result and out_stall is low; a byte giving two or three results
// holds the input while the queue drains. Reset is synchronous and returns
// the line state and max_args (100) to their defaults. out_stall
// back-pressures through the queue into in_stall.

module shell_argument_splitter_unit import sas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [6:0] arg_index,
  output logic [2:0] kind,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] max_args
);

  logic        in_full;
  logic [7:0]  held_byte;
  logic        held_eol;
  logic [6:0]  max_args_reg;
  line_state_t line_state;
  line_state_t line_state_next;
  packet_t     pkt;
  logic        q_free;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && q_free;
  assign in_stall  = in_full && !q_free;

  sas_step u_step (
    .in_byte     (held_byte),
    .end_of_line (held_eol),
    .cur         (line_state),
    .max_args    (max_args_reg),
    .nxt         (line_state_next),
    .pkt         (pkt)
  );

  sas_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .pkt       (pkt),
    .free      (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .arg_index (arg_index),
    .kind      (kind),
    .last      (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      line_state   <= LINE_CLEAR;
      max_args_reg <= MAX_ARGS_RESET;
    end else begin
      if (cfg_valid) begin
        max_args_reg <= max_args;
      end
      if (advance) begin
        line_state <= line_state_next;
      end
      // hold the item until the queue can take its results
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= in_byte;
      held_eol  <= end_of_line;
    end
  end

endmodule
